@@ rtl/pfwf_pkg.sv @@
// Package for the PCM16 frame window former.
// Holds field widths, register indexes, action codes and parameter defaults.
// No dependencies.
package pfwf_pkg;

    // Field widths of the transaction payloads.
    localparam int ACTION_W     = 1;
    localparam int BYTE_W       = 8;
    localparam int COEF_IDX_W   = 10;
    localparam int COEF_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int FRAME_POS_W  = 10;

    // Configuration port.
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 11;
    localparam int FRAME_SIZE_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 1'b1;

    localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 11'd1024;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_AUDIO_BYTE = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_COEF_LOAD  = 1'b1;

    // Channel modes.
    localparam logic MODE_MONO   = 1'b0;
    localparam logic MODE_STEREO = 1'b1;

    // Parameter defaults.
    localparam int MAX_FRAME_DFLT      = 1024;
    localparam int COEF_FRAC_BITS_DFLT = 15;

endpackage

@@ rtl/pcm16_frame_window_former_unit.sv @@
// Top level of the PCM16 frame window former; uses pfwf_pkg.
// Byte assembly, a window table memory and a three stage result pipeline.
// Results pass through stage 1, stage 2 and the output register. Throughput, for audio bytes
// and coefficient loads: one per cycle unless the input is stalled; the table's separate
// write and read ports keep a load and a sample read from competing. Reset (synchronous,
// active low) clears the pipeline, byte assembly, frame counter and registers, not the table.
module pcm16_frame_window_former_unit #(
    parameter int MAX_FRAME      = pfwf_pkg::MAX_FRAME_DFLT,
    parameter int COEF_FRAC_BITS = pfwf_pkg::COEF_FRAC_BITS_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [pfwf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfwf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pfwf_pkg::ACTION_W-1:0]       i_action,
    input  logic [pfwf_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [pfwf_pkg::COEF_IDX_W-1:0]     i_coef_index,
    input  logic [pfwf_pkg::COEF_W-1:0]         i_coef_value,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pfwf_pkg::SAMPLE_W-1:0] o_windowed_sample,
    output logic signed [pfwf_pkg::SAMPLE_W-1:0] o_mono_sample,
    output logic [pfwf_pkg::SAMPLE_W-1:0]       o_duty_level,
    output logic [pfwf_pkg::FRAME_POS_W-1:0]    o_frame_position,
    output logic                                o_last_in_frame
);
    import pfwf_pkg::*;

    localparam int CNT_W   = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CMP_W   = (CNT_W + 1 > FRAME_SIZE_W) ? CNT_W + 1 : FRAME_SIZE_W;
    localparam int IDXC_W  = (CNT_W + 1 > COEF_IDX_W) ? CNT_W + 1 : COEF_IDX_W;
    localparam int PROD_W  = SAMPLE_W + COEF_W + 1;

    localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-SAMPLE_W+1){1'b0}},
                                                   {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-SAMPLE_W+1){1'b1}},
                                                   {(SAMPLE_W-1){1'b0}}};

    // Configuration registers.
    logic                    r_channel_mode;
    logic [FRAME_SIZE_W-1:0] r_frame_size;

    // Byte assembly and frame position.
    logic [23:0]             r_holder;
    logic [1:0]              r_phase;
    logic [CNT_W-1:0]        r_frame_cnt;

    // Window table with registered read data.
    logic [COEF_W-1:0]       r_win_mem [MAX_FRAME];
    logic [COEF_W-1:0]       r_rd_q;

    // Stage 1: assembled sample, coefficient arriving from memory.
    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic [CNT_W-1:0]           r_s1_pos;
    logic                       r_s1_last;

    // Stage 2: product.
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_s2_sample;
    logic [CNT_W-1:0]           r_s2_pos;
    logic                       r_s2_last;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_win;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [CNT_W-1:0]           r_out_pos;
    logic                       r_out_last;

    logic                       w_en1, w_en2, w_en3;
    logic                       w_accept, w_audio, w_load, w_done, w_idx_ok;
    logic signed [SAMPLE_W-1:0] w_left, w_right, w_sample;
    logic signed [SAMPLE_W:0]   w_sum, w_sum_adj, w_half;
    logic [CMP_W-1:0]           w_fs_ext, w_size, w_pos_inc;
    logic                       w_last;
    logic [CNT_W-1:0]           w_cnt_next;
    logic signed [PROD_W-1:0]   w_mul_a, w_mul_b, w_q;
    logic signed [SAMPLE_W-1:0] w_win_sat;

    // Stage enables; a stage moves when it is empty or the next one moves.
    assign w_en3      = !r_out_valid || !i_out_stall;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    assign w_accept = i_in_valid && w_en1;
    assign w_audio  = w_accept && (i_action == ACT_AUDIO_BYTE);
    assign w_load   = w_accept && (i_action == ACT_COEF_LOAD);
    assign w_idx_ok = IDXC_W'(i_coef_index) < IDXC_W'(MAX_FRAME);

    // A sample completes on the second byte in mono and the fourth in stereo.
    assign w_done = w_audio &&
                    (((r_channel_mode == MODE_MONO) && (r_phase == 2'd1)) ||
                     ((r_channel_mode == MODE_STEREO) && (r_phase == 2'd3)));

    // Sample assembly and stereo down-mix, truncated toward zero.
    always_comb begin
        w_left    = $signed(r_holder[15:0]);
        w_right   = $signed({i_data_byte, r_holder[23:16]});
        w_sum     = {w_left[SAMPLE_W-1], w_left} + {w_right[SAMPLE_W-1], w_right};
        w_sum_adj = w_sum + {{SAMPLE_W{1'b0}}, w_sum[SAMPLE_W]};
        w_half    = w_sum_adj >>> 1;
        if (r_channel_mode == MODE_STEREO) begin
            w_sample = w_half[SAMPLE_W-1:0];
        end else begin
            w_sample = $signed({i_data_byte, r_holder[7:0]});
        end
    end

    // Effective frame size and end-of-frame detection.
    always_comb begin
        w_fs_ext = CMP_W'(r_frame_size);
        if ((r_frame_size == '0) || (w_fs_ext > CMP_W'(MAX_FRAME))) begin
            w_size = CMP_W'(MAX_FRAME);
        end else begin
            w_size = w_fs_ext;
        end
        w_pos_inc  = CMP_W'(r_frame_cnt) + CMP_W'(1);
        w_last     = (w_pos_inc >= w_size);
        w_cnt_next = w_last ? '0 : r_frame_cnt + CNT_W'(1);
    end

    // Configuration, byte assembly and frame counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mode <= MODE_MONO;
            r_frame_size   <= FRAME_SIZE_RST;
            r_holder       <= '0;
            r_phase        <= '0;
            r_frame_cnt    <= '0;
        end else begin
            if (w_audio) begin
                if (w_done) begin
                    r_phase     <= '0;
                    r_frame_cnt <= w_cnt_next;
                end else begin
                    r_holder[8*r_phase +: 8] <= i_data_byte;
                    r_phase                  <= r_phase + 2'd1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHANNEL_MODE: begin
                        r_channel_mode <= i_cfg_data[0];
                        r_phase        <= '0;
                    end
                    CFG_FRAME_SIZE: begin
                        r_frame_size <= FRAME_SIZE_W'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Window table. A load and a later sample read are in separate cycles, so the
    // read always sees every earlier load.
    always_ff @(posedge i_clk) begin
        if (w_load && w_idx_ok) begin
            r_win_mem[CNT_W'(i_coef_index)] <= i_coef_value;
        end
        if (w_done) begin
            r_rd_q <= r_win_mem[r_frame_cnt];
        end
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_s1_sample <= w_sample;
            r_s1_pos    <= r_frame_cnt;
            r_s1_last   <= w_last;
        end
    end

    // Stage 2: sample times coefficient.
    assign w_mul_a = PROD_W'(r_s1_sample);
    assign w_mul_b = $signed(PROD_W'(r_rd_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_prod      <= w_mul_a * w_mul_b;
            r_s2_sample <= r_s1_sample;
            r_s2_pos    <= r_s1_pos;
            r_s2_last   <= r_s1_last;
        end
    end

    // Stage 3: arithmetic shift and saturation into the output register.
    always_comb begin
        w_q = r_prod >>> COEF_FRAC_BITS;
        if (w_q > SAT_HI) begin
            w_win_sat = SAT_HI[SAMPLE_W-1:0];
        end else if (w_q < SAT_LO) begin
            w_win_sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            w_win_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r_out_win    <= w_win_sat;
            r_out_sample <= r_s2_sample;
            r_out_pos    <= r_s2_pos;
            r_out_last   <= r_s2_last;
        end
    end

    // Output transaction; the duty level is the sample offset by half scale.
    assign o_out_valid       = r_out_valid;
    assign o_windowed_sample = r_out_win;
    assign o_mono_sample     = r_out_sample;
    assign o_duty_level      = {~r_out_sample[SAMPLE_W-1], r_out_sample[SAMPLE_W-2:0]};
    assign o_frame_position  = FRAME_POS_W'(r_out_pos);
    assign o_last_in_frame   = r_out_last;

endmodule

@@ rtl/pfwf_checker.sv @@
// Port-level checker for the PCM16 frame window former, bound to its top level.
// Uses pfwf_pkg for field widths.
module pfwf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [pfwf_pkg::SAMPLE_W-1:0] o_windowed_sample,
    input logic signed [pfwf_pkg::SAMPLE_W-1:0] o_mono_sample,
    input logic [pfwf_pkg::SAMPLE_W-1:0]        o_duty_level
);
    import pfwf_pkg::*;

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The input side only backs up when the output is full and stalled.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output can drain");

    // The duty level is the sample offset by half of full scale.
    a_duty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_level ==
                         {~o_mono_sample[SAMPLE_W-1], o_mono_sample[SAMPLE_W-2:0]}))
        else $error("duty level does not match sample");

    // A stalled result transaction stays and keeps its windowed and mono samples.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_windowed_sample) && $stable(o_mono_sample)))
        else $error("result payload changed while stalled");

endmodule

bind pcm16_frame_window_former_unit pfwf_checker u_pfwf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_windowed_sample (o_windowed_sample),
    .o_mono_sample     (o_mono_sample),
    .o_duty_level      (o_duty_level)
);

@@ tb/tb_pcm16_frame_window_former_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pcm16_frame_window_former_unit: byte assembly, stereo down-mix,
// windowing, duty level and frame position, checked against a predictor kept in this file.
// Depends on pfwf_pkg and the unit itself.
module tb_pcm16_frame_window_former_unit;
    import pfwf_pkg::*;

    localparam int STUCK_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 160;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] windowed;
        logic signed [SAMPLE_W-1:0] mono;
        logic [SAMPLE_W-1:0]        duty;
        logic [FRAME_POS_W-1:0]     position;
        logic                       last;
    } pcm_result_t;

    // Clock, reset and block ports; the inputs are at known values from time zero.
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = CFG_CHANNEL_MODE;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [ACTION_W-1:0]         i_action = ACT_AUDIO_BYTE;
    logic [BYTE_W-1:0]           i_data_byte = '0;
    logic [COEF_IDX_W-1:0]       i_coef_index = '0;
    logic [COEF_W-1:0]           i_coef_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_windowed_sample;
    logic signed [SAMPLE_W-1:0]  o_mono_sample;
    logic [SAMPLE_W-1:0]         o_duty_level;
    logic [FRAME_POS_W-1:0]      o_frame_position;
    logic                        o_last_in_frame;

    // Predictor state: configuration, byte assembly, frame counter and window table.
    logic                        mdl_mode = MODE_MONO;
    logic [FRAME_SIZE_W-1:0]     mdl_frame_size = FRAME_SIZE_RST;
    logic [23:0]                 asm_holder = '0;
    int                          asm_phase = 0;
    int                          frame_pos = 0;
    logic [COEF_W-1:0]           coef_table [MAX_FRAME_DFLT];
    bit                          coef_loaded [MAX_FRAME_DFLT];

    pcm_result_t                 expected_samples [$];
    int                          errors = 0;
    bit                          steady = 1'b0;
    int                          stuck_cycles = 0;
    int                          stall_left = 0;

    pcm16_frame_window_former_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_windowed_sample (o_windowed_sample),
        .o_mono_sample     (o_mono_sample),
        .o_duty_level      (o_duty_level),
        .o_frame_position  (o_frame_position),
        .o_last_in_frame   (o_last_in_frame)
    );

    always #2 i_clk = ~i_clk;

    // Sample times coefficient, floored by the arithmetic shift, then saturated to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] window_product(
        input logic signed [SAMPLE_W-1:0] s, input logic [COEF_W-1:0] c);
        longint prod;
        prod = (longint'(s) * longint'(c)) >>> COEF_FRAC_BITS_DFLT;
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        return SAMPLE_W'(prod);
    endfunction

    // Advances the predictor by one accepted transaction and queues any finished sample.
    task automatic predict_mono_result(input logic [ACTION_W-1:0] act, input logic [7:0] b,
                                       input logic [COEF_IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] val);
        logic signed [SAMPLE_W-1:0] left_s;
        logic signed [SAMPLE_W-1:0] right_s;
        logic signed [SAMPLE_W-1:0] sample;
        int size;
        pcm_result_t res;
        if (act == ACT_COEF_LOAD) begin
            coef_table[idx] = val;
            coef_loaded[idx] = 1'b1;
            return;
        end
        if (mdl_mode == MODE_MONO) begin
            if (asm_phase == 0) begin
                asm_holder = {16'h0000, b};
                asm_phase = 1;
                return;
            end
            sample = {b, asm_holder[7:0]};
        end else begin
            if (asm_phase < 3) begin
                asm_holder = asm_holder | (24'(b) << (8 * asm_phase));
                asm_phase++;
                return;
            end
            left_s = asm_holder[15:0];
            right_s = {b, asm_holder[23:16]};
            // Signed integer division truncates toward zero, as the down-mix requires.
            sample = SAMPLE_W'((int'(left_s) + int'(right_s)) / 2);
        end
        asm_phase = 0;
        asm_holder = '0;
        size = (mdl_frame_size == 0 || mdl_frame_size > MAX_FRAME_DFLT) ?
               MAX_FRAME_DFLT : int'(mdl_frame_size);
        res.windowed = window_product(sample, coef_table[frame_pos]);
        res.mono = sample;
        res.duty = sample + 16'h8000;
        res.position = FRAME_POS_W'(frame_pos);
        res.last = (frame_pos + 1 >= size);
        frame_pos = res.last ? 0 : frame_pos + 1;
        expected_samples.push_back(res);
    endtask

    // Mostly short gaps, a few long ones, none while a steady stretch runs.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 16'h8000;
        if (r < 30) return COEF_W'($urandom_range(0, 65535));
        return COEF_W'($urandom_range(0, 32768));
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] corners [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        if ($urandom_range(0, 99) < 15) return corners[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one input transaction and waits for its acceptance; valid stays high afterward.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [7:0] b,
                             input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_data_byte  <= b;
        i_coef_index <= idx;
        i_coef_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_mono_result(act, b, idx, val);
    endtask

    task automatic send_coef(input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        send_item(ACT_COEF_LOAD, 8'($urandom_range(0, 255)), idx, val);
    endtask

    // A byte that completes a sample reads the table, so its entry is loaded first if needed.
    task automatic send_audio(input logic [7:0] b);
        bit completes;
        completes = (mdl_mode == MODE_MONO) ? (asm_phase == 1) : (asm_phase == 3);
        if (completes && !coef_loaded[frame_pos])
            send_coef(COEF_IDX_W'(frame_pos), random_coef());
        send_item(ACT_AUDIO_BYTE, b, COEF_IDX_W'($urandom_range(0, 1023)),
                  COEF_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_sample16(input logic [15:0] v);
        send_audio(v[7:0]);
        send_audio(v[15:8]);
    endtask

    // Register writes happen only once the block has drained and settled.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CHANNEL_MODE) begin
            mdl_mode = data[0];
            asm_phase = 0;
            asm_holder = '0;
        end else begin
            mdl_frame_size = data;
        end
    endtask

    // Full-scale and minus-one mono samples against zero, unity, above-unity and half coefficients.
    task automatic test_mono_extremes();
        steady = 1'b1;
        send_coef(10'd0, 16'h8000);
        send_coef(10'd1, 16'h0000);
        send_coef(10'd2, 16'hFFFF);
        send_coef(10'd3, 16'h4000);
        send_sample16(16'h8000);
        send_sample16(16'h7FFF);
        send_sample16(16'h7FFF);
        send_sample16(16'hFFFF);
        steady = 1'b0;
    endtask

    // Stereo down-mix, a load between the bytes of a sample, and a frame size below the position.
    task automatic test_stereo_downmix();
        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_STEREO));
        write_reg(CFG_FRAME_SIZE, CFG_DATA_W'(2));
        send_coef(10'd4, 16'h7FFF);
        send_audio(8'h00);
        send_audio(8'h80);
        send_audio(8'h00);
        send_coef(10'd5, 16'h1234);
        send_audio(8'h80);
        send_sample16(16'h8000);
        send_sample16(16'hFFFF);
        send_sample16(16'h7FFF);
        send_sample16(16'h7FFF);
    endtask

    // A mode write drops a partial sample; frame size zero and one.
    task automatic test_mode_switch_and_frame_size();
        send_audio(8'h55);
        send_audio(8'hAA);
        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_MONO));
        write_reg(CFG_FRAME_SIZE, CFG_DATA_W'(0));
        send_sample16(16'h0001);
        write_reg(CFG_FRAME_SIZE, CFG_DATA_W'(1));
        send_sample16(16'hC000);
        send_sample16(16'h3FFF);
    endtask

    // Random phases over several settings; each phase is mostly audio with some table loads.
    task automatic test_random_traffic();
        int ph;
        int phase_items;
        logic [CFG_DATA_W-1:0] fs;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady = (ph % 3 == 2);
            case (ph)
                0: fs = CFG_DATA_W'(1);
                1: fs = CFG_DATA_W'(1024);
                2: fs = CFG_DATA_W'(2047);
                3: fs = CFG_DATA_W'(0);
                4: fs = CFG_DATA_W'(1025);
                default: fs = CFG_DATA_W'($urandom_range(1, 24));
            endcase
            write_reg(CFG_FRAME_SIZE, fs);
            if (ph < 2 || $urandom_range(0, 2) == 0)
                write_reg(CFG_CHANNEL_MODE, (ph < 2) ? CFG_DATA_W'(ph % 2) :
                                                       CFG_DATA_W'($urandom_range(0, 1)));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 10)
                    send_coef(COEF_IDX_W'($urandom_range(0, 1023)), random_coef());
                else
                    send_audio(random_byte());
                phase_items++;
            end
        end
        steady = 1'b0;
    endtask

    task automatic report_field(input string name, input logic signed [31:0] expv,
                                input logic signed [31:0] actv);
        if (expv !== actv) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
        end
    endtask

    // Result checking, output stall pattern and the no-progress watchdog.
    always @(posedge i_clk) begin : result_check
        pcm_result_t exp_res;
        int r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, mono %0d position %0d",
                         $time, o_mono_sample, o_frame_position);
            end else begin
                exp_res = expected_samples.pop_front();
                report_field("windowed_sample", exp_res.windowed, o_windowed_sample);
                report_field("mono_sample", exp_res.mono, o_mono_sample);
                report_field("duty_level", exp_res.duty, o_duty_level);
                report_field("frame_position", exp_res.position, o_frame_position);
                report_field("last_in_frame", exp_res.last, o_last_in_frame);
            end
        end

        if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (steady || r < 55) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(1, 30);
            end else if (r < 90) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        stall_left--;

        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("pcm16_frame_window_former_unit: mismatch");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_mono_extremes();
        test_stereo_downmix();
        test_mode_switch_and_frame_size();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("pcm16_frame_window_former_unit: match");
        else
            $display("pcm16_frame_window_former_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pfwf_pkg.sv
rtl/pcm16_frame_window_former_unit.sv
rtl/pfwf_checker.sv
tb/tb_pcm16_frame_window_former_unit.sv
